/* rtl/core/m3dor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3dor_pkg
// Shared types and constants for the 3D mesh/torus dimension-order router.
// ----------------------------------------------------------------------------
package m3dor_pkg;

    localparam int MAX_EXTENT = 8;
    localparam int NODE_W     = 9;
    localparam int EXT_W      = 4;
    localparam int COORD_W    = $clog2(MAX_EXTENT);
    localparam int PLANE_W    = $clog2(MAX_EXTENT * MAX_EXTENT + 1);
    localparam int SPAN_W     = NODE_W + 1;
    localparam int IDX_W      = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_X_DIM      = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_DIM      = 3'd1;
    localparam logic [IDX_W-1:0] REG_Z_DIM      = 3'd2;
    localparam logic [IDX_W-1:0] REG_WRAPAROUND = 3'd3;

    typedef struct packed {
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dest_node;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] hop_node;
        logic              last;
        logic              error;
    } rsp_t;

    typedef struct packed {
        logic [EXT_W-1:0] x_dim;
        logic [EXT_W-1:0] y_dim;
        logic [EXT_W-1:0] z_dim;
        logic             wraparound;
    } cfg_t;

    // A classified route request handed from the front end to the walker.
    typedef struct packed {
        logic                error;
        logic [NODE_W-1:0]   src_node;
        logic [NODE_W-1:0]   dest_node;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  sz;
        logic [COORD_W-1:0]  dx;
        logic [COORD_W-1:0]  dy;
        logic [COORD_W-1:0]  dz;
        logic [PLANE_W-1:0]  plane;
        logic [SPAN_W-1:0]   total;
    } job_t;

endpackage

`default_nettype wire

/* rtl/core/m3dor_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3dor_cfg
// Configuration register file: extents and wraparound mode.
// ----------------------------------------------------------------------------
module m3dor_cfg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [m3dor_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [m3dor_pkg::EXT_W-1:0]  cfg_data,
    output m3dor_pkg::cfg_t               cfg
);
    import m3dor_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_DIM:      cfg_next.x_dim      = cfg_data;
                REG_Y_DIM:      cfg_next.y_dim      = cfg_data;
                REG_Z_DIM:      cfg_next.z_dim      = cfg_data;
                REG_WRAPAROUND: cfg_next.wraparound = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_dim      <= EXT_W'(4);
            cfg_reg.y_dim      <= EXT_W'(4);
            cfg_reg.z_dim      <= EXT_W'(4);
            cfg_reg.wraparound <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/m3dor_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3dor_front
// Accepts a request, checks the configuration and splits both node numbers
// into coordinates with a bit-serial divider (skipped for an unusable configuration), then queues the job.
// ----------------------------------------------------------------------------
module m3dor_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire m3dor_pkg::cfg_t cfg,
    input  wire logic            push,
    output logic                 full,
    input  wire m3dor_pkg::req_t req,
    output logic                 jq_push,
    input  wire logic            jq_full,
    output m3dor_pkg::job_t      job
);
    import m3dor_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_DIVX, F_DIVY, F_PUSH} fstate_t;

    typedef struct packed {
        logic [NODE_W-1:0] quo;
        logic [EXT_W-1:0]  rem;
    } divs_t;

    localparam int CNT_W = $clog2(NODE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NODE_W - 1);

    // One restoring-division step: quotient bits shift in from the bottom
    // as dividend bits leave from the top.
    function automatic divs_t div_step(logic [NODE_W-1:0] quo, logic [EXT_W-1:0] rem,
                                       logic [EXT_W-1:0] d);
        logic [EXT_W:0] trial;
        divs_t r;
        trial = {rem, quo[NODE_W-1]};
        if (trial >= {1'b0, d})
        begin
            r.rem = EXT_W'(trial - {1'b0, d});
            r.quo = {quo[NODE_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[EXT_W-1:0];
            r.quo = {quo[NODE_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic ext_ok(logic [EXT_W-1:0] e, logic wrap);
        return (e >= EXT_W'(2)) && (e <= EXT_W'(MAX_EXTENT)) && !(wrap && (e < EXT_W'(3)));
    endfunction

    fstate_t           state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NODE_W-1:0] squo_reg;
    logic [NODE_W-1:0] dquo_reg;
    logic [EXT_W-1:0]  srem_reg;
    logic [EXT_W-1:0]  drem_reg;
    job_t              job_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic [SPAN_W-1:0]  total_reg;

    logic [EXT_W-1:0] divisor;
    divs_t            sstep;
    divs_t            dstep;
    logic             cfg_bad;

    assign divisor = (state_reg == F_DIVY) ? cfg.y_dim : cfg.x_dim;
    assign sstep   = div_step(squo_reg, srem_reg, divisor);
    assign dstep   = div_step(dquo_reg, drem_reg, divisor);
    assign cfg_bad = !ext_ok(cfg.x_dim, cfg.wraparound) ||
                     !ext_ok(cfg.y_dim, cfg.wraparound) ||
                     !ext_ok(cfg.z_dim, cfg.wraparound);

    assign full    = (state_reg != F_IDLE);
    assign jq_push = (state_reg == F_PUSH) && !jq_full;
    assign job     = job_reg;

    // Plane size and node count follow the configuration, one product per register.
    always_ff @(posedge clk)
    begin
        plane_reg <= PLANE_W'(cfg.x_dim) * PLANE_W'(cfg.y_dim);
        total_reg <= SPAN_W'(plane_reg) * SPAN_W'(cfg.z_dim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        job_reg.src_node  <= req.src_node;
                        job_reg.dest_node <= req.dest_node;
                        job_reg.error     <= cfg_bad;
                        squo_reg          <= req.src_node;
                        dquo_reg          <= req.dest_node;
                        srem_reg          <= '0;
                        drem_reg          <= '0;
                        cnt_reg           <= '0;
                        state_reg         <= cfg_bad ? F_PUSH : F_DIVX;
                    end
                end
                F_DIVX:
                begin
                    squo_reg <= sstep.quo;
                    dquo_reg <= dstep.quo;
                    srem_reg <= sstep.rem;
                    drem_reg <= dstep.rem;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        job_reg.sx <= sstep.rem[COORD_W-1:0];
                        job_reg.dx <= dstep.rem[COORD_W-1:0];
                        srem_reg   <= '0;
                        drem_reg   <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= F_DIVY;
                    end
                end
                F_DIVY:
                begin
                    squo_reg <= sstep.quo;
                    dquo_reg <= dstep.quo;
                    srem_reg <= sstep.rem;
                    drem_reg <= dstep.rem;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        // A node is in range exactly when its z quotient is below the z extent.
                        job_reg.sy    <= sstep.rem[COORD_W-1:0];
                        job_reg.dy    <= dstep.rem[COORD_W-1:0];
                        job_reg.sz    <= sstep.quo[COORD_W-1:0];
                        job_reg.dz    <= dstep.quo[COORD_W-1:0];
                        job_reg.error <= (sstep.quo >= NODE_W'(cfg.z_dim)) ||
                                         (dstep.quo >= NODE_W'(cfg.z_dim));
                        job_reg.plane <= plane_reg;
                        job_reg.total <= total_reg;
                        cnt_reg       <= '0;
                        state_reg     <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!jq_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/m3dor_jobq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3dor_jobq
// Short queue of classified jobs between the front end and the walker.
// ----------------------------------------------------------------------------
module m3dor_jobq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire m3dor_pkg::job_t wr_job,
    output logic                 jq_full,
    input  wire logic            rd_en,
    output logic                 rd_valid,
    output m3dor_pkg::job_t      rd_job
);
    import m3dor_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;

    assign jq_full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/m3dor_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3dor_back
// Route walker: steps X, then Y, then Z, one hop per cycle unless a stalled
// pop holds it, into an output register that the consumer pops.
// ----------------------------------------------------------------------------
module m3dor_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire m3dor_pkg::cfg_t cfg,
    input  wire logic            jq_valid,
    input  wire m3dor_pkg::job_t jq_job,
    output logic                 jq_pop,
    output logic                 empty,
    input  wire logic            pop,
    output m3dor_pkg::rsp_t      rsp
);
    import m3dor_pkg::*;

    typedef enum logic {B_IDLE, B_WALK} bstate_t;

    typedef struct packed {
        logic               fwd;
        logic               wrap;
        logic [COORD_W-1:0] coord;
    } step_t;

    function automatic step_t advance(logic [COORD_W-1:0] cur, logic [COORD_W-1:0] tgt,
                                      logic [EXT_W-1:0] e, logic tie_back, logic torus);
        logic [EXT_W-1:0] c;
        logic [EXT_W-1:0] t;
        logic [EXT_W-1:0] f;
        logic [EXT_W-1:0] b;
        step_t r;
        c = EXT_W'(cur);
        t = EXT_W'(tgt);
        f = (t >= c) ? (t - c) : (t + e - c);
        b = e - f;
        r.fwd = torus ? ((f < b) || ((f == b) && !tie_back)) : (t > c);
        if (r.fwd)
        begin
            r.wrap  = (c == e - 1'b1);
            r.coord = r.wrap ? '0 : COORD_W'(c + 1'b1);
        end
        else
        begin
            r.wrap  = (c == '0);
            r.coord = r.wrap ? COORD_W'(e - 1'b1) : COORD_W'(c - 1'b1);
        end
        return r;
    endfunction

    bstate_t            state_reg;
    job_t               job_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] z_reg;
    logic [NODE_W-1:0]  node_reg;
    rsp_t               rsp_reg;
    logic               ovalid_reg;

    logic               slot_free;
    logic               load;
    logic               walk;
    logic               first_last;
    logic [COORD_W-1:0] cur;
    logic [COORD_W-1:0] tgt;
    logic [EXT_W-1:0]   ext;
    logic               tie_back;
    logic [SPAN_W-1:0]  stride;
    logic [SPAN_W-1:0]  span;
    step_t              st;
    logic [COORD_W-1:0] x_next;
    logic [COORD_W-1:0] y_next;
    logic [COORD_W-1:0] z_next;
    logic [SPAN_W-1:0]  node_wide;
    logic [NODE_W-1:0]  node_next;
    logic               hop_last;

    assign slot_free  = !ovalid_reg || pop;
    assign load       = (state_reg == B_IDLE) && jq_valid && slot_free;
    assign walk       = (state_reg == B_WALK) && slot_free;
    assign jq_pop     = load;
    assign first_last = jq_job.error || (jq_job.src_node == jq_job.dest_node);
    assign empty      = !ovalid_reg;
    assign rsp        = rsp_reg;

    // Pick the lowest dimension not yet at its target, with its stride and ring span.
    always_comb
    begin
        if (x_reg != job_reg.dx)
        begin
            cur      = x_reg;
            tgt      = job_reg.dx;
            ext      = cfg.x_dim;
            tie_back = job_reg.sx[0];
            stride   = SPAN_W'(1);
            span     = SPAN_W'(cfg.x_dim);
        end
        else if (y_reg != job_reg.dy)
        begin
            cur      = y_reg;
            tgt      = job_reg.dy;
            ext      = cfg.y_dim;
            tie_back = job_reg.sy[0];
            stride   = SPAN_W'(cfg.x_dim);
            span     = SPAN_W'(job_reg.plane);
        end
        else
        begin
            cur      = z_reg;
            tgt      = job_reg.dz;
            ext      = cfg.z_dim;
            tie_back = job_reg.sz[0];
            stride   = SPAN_W'(job_reg.plane);
            span     = job_reg.total;
        end
    end

    assign st = advance(cur, tgt, ext, tie_back, cfg.wraparound);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (x_reg != job_reg.dx)
        begin
            x_next = st.coord;
        end
        else if (y_reg != job_reg.dy)
        begin
            y_next = st.coord;
        end
        else
        begin
            z_next = st.coord;
        end
        // Wrapping around a ring moves back or forward by a whole ring's span.
        case ({st.fwd, st.wrap})
            2'b10:   node_wide = SPAN_W'(node_reg) + stride;
            2'b11:   node_wide = SPAN_W'(node_reg) + stride - span;
            2'b00:   node_wide = SPAN_W'(node_reg) - stride;
            2'b01:   node_wide = SPAN_W'(node_reg) - stride + span;
            default: node_wide = SPAN_W'(node_reg);
        endcase
    end

    assign node_next = node_wide[NODE_W-1:0];
    assign hop_last  = (x_next == job_reg.dx) && (y_next == job_reg.dy) &&
                       (z_next == job_reg.dz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (slot_free)
            begin
                ovalid_reg <= load || walk;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (load)
                    begin
                        job_reg          <= jq_job;
                        x_reg            <= jq_job.sx;
                        y_reg            <= jq_job.sy;
                        z_reg            <= jq_job.sz;
                        node_reg         <= jq_job.src_node;
                        rsp_reg.hop_node <= jq_job.src_node;
                        rsp_reg.last     <= first_last;
                        rsp_reg.error    <= jq_job.error;
                        state_reg        <= first_last ? B_IDLE : B_WALK;
                    end
                end
                B_WALK:
                begin
                    if (walk)
                    begin
                        x_reg            <= x_next;
                        y_reg            <= y_next;
                        z_reg            <= z_next;
                        node_reg         <= node_next;
                        rsp_reg.hop_node <= node_next;
                        rsp_reg.last     <= hop_last;
                        rsp_reg.error    <= 1'b0;
                        state_reg        <= hop_last ? B_IDLE : B_WALK;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mesh3d_dimension_order_route_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh3d_dimension_order_route_top
// Dimension-order (X, then Y, then Z) router for a 3D mesh or torus: one
// request in, every node on the path out, the final one marked last.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// req       push / full               req_t: src_node, dest_node
// rsp       empty / pop               rsp_t: hop_node, last, error
// cfg       cfg_valid / cfg_ready     cfg_index (register), cfg_data
//
// The front end works on one request at a time, full until it is queued: 9
// divider steps per dimension for both node numbers, plus accept and enqueue;
// with an unusable configuration it skips the divider. The walker emits one
// hop per cycle while pops keep up; a two-entry job queue lets the two sides
// overlap and stall independently. A stalled pop holds the walker; a full job
// queue holds the front end. Reset is asynchronous, active low, and restores
// all extents to 4 in mesh mode.
// ----------------------------------------------------------------------------
module mesh3d_dimension_order_route_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire m3dor_pkg::req_t              req,
    output logic                              empty,
    input  wire logic                         pop,
    output m3dor_pkg::rsp_t                   rsp,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [m3dor_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [m3dor_pkg::EXT_W-1:0]  cfg_data
);
    import m3dor_pkg::*;

    cfg_t cfg;
    job_t fe_job;
    job_t jq_job;
    logic jq_push;
    logic jq_full;
    logic jq_valid;
    logic jq_pop;

    m3dor_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    m3dor_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .full    (full),
        .req     (req),
        .jq_push (jq_push),
        .jq_full (jq_full),
        .job     (fe_job)
    );

    m3dor_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (jq_push),
        .wr_job   (fe_job),
        .jq_full  (jq_full),
        .rd_en    (jq_pop),
        .rd_valid (jq_valid),
        .rd_job   (jq_job)
    );

    m3dor_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .jq_valid (jq_valid),
        .jq_job   (jq_job),
        .jq_pop   (jq_pop),
        .empty    (empty),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D mesh/torus dimension-order router. Requests
// go in through the push/full side in random bursts and hops are drained
// through the empty/pop side under a changing stall pattern. A route tracker
// mirrors the configuration, walks every accepted request in X, Y, Z order
// and compares each hop field by field. The run steps through mesh and torus
// settings, including the smallest and largest extents and unroutable ones.
// ----------------------------------------------------------------------------
module tb_top;
    import m3dor_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd6;

    typedef enum int {POP_STEADY, POP_ALTERNATE, POP_RANDOM, POP_LONG} pop_mode_e;

    class route_tracker;
        rsp_t             pending_hops[$];
        logic [EXT_W-1:0] x_ext;
        logic [EXT_W-1:0] y_ext;
        logic [EXT_W-1:0] z_ext;
        logic             torus;
        int               errors;

        function new();
            x_ext  = 4'd4;
            y_ext  = 4'd4;
            z_ext  = 4'd4;
            torus  = 1'b0;
            errors = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(input logic [IDX_W-1:0] index, input logic [EXT_W-1:0] data);
            case (index)
                REG_X_DIM:      x_ext = data;
                REG_Y_DIM:      y_ext = data;
                REG_Z_DIM:      z_ext = data;
                REG_WRAPAROUND: torus = data[0];
                default: ;
            endcase
        endfunction

        function bit extent_usable(input logic [EXT_W-1:0] e);
            if (e < 2 || e > MAX_EXTENT)
                return 1'b0;
            return !(torus && e < 3);
        endfunction

        // Number of nodes in the network, or zero when no route can be taken.
        function int unsigned route_span();
            if (!extent_usable(x_ext) || !extent_usable(y_ext) || !extent_usable(z_ext))
                return 0;
            return int'(x_ext) * int'(y_ext) * int'(z_ext);
        endfunction

        // On a torus tie the walk goes backward when the source coordinate is odd.
        function int unsigned ring_step(input int unsigned cur, input int unsigned tgt,
                                        input int unsigned ext, input bit odd_src);
            int unsigned fwd;
            int unsigned bwd;
            if (!torus)
                return (tgt > cur) ? cur + 1 : cur - 1;
            fwd = (tgt + ext - cur) % ext;
            bwd = ext - fwd;
            if (fwd < bwd || (fwd == bwd && !odd_src))
                return (cur + 1) % ext;
            return (cur + ext - 1) % ext;
        endfunction

        function void add_hop(input logic [NODE_W-1:0] node, input logic last,
                              input logic err);
            rsp_t h;
            h.hop_node = node;
            h.last     = last;
            h.error    = err;
            pending_hops.push_back(h);
        endfunction

        function void add_route(input req_t r);
            int unsigned span;
            int unsigned xe, ye, ze;
            int unsigned x, y, z, tx, ty, tz, node;
            bit ox, oy, oz;
            span = route_span();
            if (span == 0 || r.src_node >= span || r.dest_node >= span) begin
                add_hop(r.src_node, 1'b1, 1'b1);
                return;
            end
            xe = x_ext;
            ye = y_ext;
            ze = z_ext;
            x  = r.src_node % xe;
            y  = (r.src_node / xe) % ye;
            z  = r.src_node / (xe * ye);
            tx = r.dest_node % xe;
            ty = (r.dest_node / xe) % ye;
            tz = r.dest_node / (xe * ye);
            ox = x[0];
            oy = y[0];
            oz = z[0];
            add_hop(r.src_node, r.src_node == r.dest_node, 1'b0);
            while (x != tx) begin
                x = ring_step(x, tx, xe, ox);
                node = (z * ye + y) * xe + x;
                add_hop(NODE_W'(node), node == r.dest_node, 1'b0);
            end
            while (y != ty) begin
                y = ring_step(y, ty, ye, oy);
                node = (z * ye + y) * xe + x;
                add_hop(NODE_W'(node), node == r.dest_node, 1'b0);
            end
            while (z != tz) begin
                z = ring_step(z, tz, ze, oz);
                node = (z * ye + y) * xe + x;
                add_hop(NODE_W'(node), node == r.dest_node, 1'b0);
            end
        endfunction

        task check_hop(input rsp_t got);
            rsp_t want;
            if (pending_hops.size() == 0) begin
                report_mismatch($sformatf("unexpected hop: node %0d last %0b error %0b",
                                          got.hop_node, got.last, got.error));
                return;
            end
            want = pending_hops.pop_front();
            if (got.hop_node !== want.hop_node)
                report_mismatch($sformatf("hop_node: got %0d, want %0d",
                                          got.hop_node, want.hop_node));
            if (got.last !== want.last)
                report_mismatch($sformatf("last: got %0b, want %0b (node %0d)",
                                          got.last, want.last, want.hop_node));
            if (got.error !== want.error)
                report_mismatch($sformatf("error: got %0b, want %0b (node %0d)",
                                          got.error, want.error, want.hop_node));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             push      = 1'b0;
    logic             full;
    req_t             req       = '0;
    logic             empty;
    logic             pop       = 1'b0;
    rsp_t             rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [EXT_W-1:0] cfg_data  = '0;

    route_tracker tracker = new();
    int           burst_left = 0;
    int           cycle_count;
    pop_mode_e    pop_mode = POP_STEADY;
    int           pop_mode_left = 0;
    int           hold_left = 0;

    mesh3d_dimension_order_route_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // The receiver switches between steady, alternating, random and long stalls.
    always @(posedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode      <= pop_mode_e'($urandom_range(0, 3));
            pop_mode_left <= $urandom_range(50, 300);
        end
        else
        begin
            pop_mode_left <= pop_mode_left - 1;
        end
        case (pop_mode)
            POP_STEADY:    pop <= 1'b1;
            POP_ALTERNATE: pop <= ~pop;
            POP_RANDOM:    pop <= ($urandom_range(0, 9) > 2);
            default:
            begin
                if (hold_left == 0)
                begin
                    pop       <= ~pop;
                    hold_left <= $urandom_range(1, 12);
                end
                else
                begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.check_hop(rsp);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    task automatic send_route(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
        req_t r;
        int   gap;
        r.src_node  = src;
        r.dest_node = dst;
        push <= 1'b1;
        req  <= r;
        do @(posedge clk); while (full);
        tracker.add_route(r);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait for every outstanding hop, then let the block settle.
    task automatic drain(input int settle);
        push <= 1'b0;
        do @(posedge clk); while (tracker.pending_hops.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Leaves cfg_valid high so that back-to-back writes keep it asserted.
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [EXT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(index, data);
    endtask

    task automatic configure(input logic [EXT_W-1:0] xe, input logic [EXT_W-1:0] ye,
                             input logic [EXT_W-1:0] ze, input logic [EXT_W-1:0] wrap);
        drain(25);
        write_reg(REG_SPARE, EXT_W'($urandom_range(0, 15)));
        write_reg(REG_X_DIM, xe);
        write_reg(REG_Y_DIM, ye);
        write_reg(REG_Z_DIM, ze);
        write_reg(REG_WRAPAROUND, wrap);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int unsigned       span;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain(0);
            span = tracker.route_span();
            if (span != 0 && $urandom_range(0, 9) < 8)
            begin
                src = NODE_W'($urandom_range(0, span - 1));
                dst = ($urandom_range(0, 7) == 0) ? src :
                      NODE_W'($urandom_range(0, span - 1));
            end
            else
            begin
                src = NODE_W'($urandom_range(0, 511));
                dst = NODE_W'($urandom_range(0, 511));
            end
            send_route(src, dst);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting, 4x4x4 mesh: same node, corners, nodes out of range.
        send_route(0, 0);
        send_route(0, 63);
        send_route(63, 0);
        send_route(64, 3);
        send_route(3, 64);
        send_route(511, 511);
        run_random(20);

        // Largest mesh: the longest route in both directions.
        configure(8, 8, 8, 4'hE);
        send_route(0, 511);
        send_route(511, 0);
        run_random(30);

        // Largest torus: ties from even and odd coordinates, and wrapping both ways.
        configure(8, 8, 8, 4'hB);
        send_route(0, 4);
        send_route(1, 5);
        send_route(0, 32);
        send_route(8, 40);
        send_route(0, 256);
        send_route(64, 320);
        send_route(7, 1);
        send_route(1, 7);
        send_route(0, 511);
        run_random(30);

        configure(2, 2, 2, 4'h0);
        send_route(0, 7);
        send_route(8, 0);
        run_random(20);

        configure(3, 3, 3, 4'h1);
        run_random(30);

        // A torus ring of two nodes cannot be routed.
        configure(3, 2, 5, 4'h1);
        send_route(0, 1);
        run_random(10);

        configure(0, 4, 4, 4'h0);
        send_route(0, 1);
        run_random(5);

        configure(15, 8, 8, 4'h0);
        send_route(0, 1);
        run_random(5);

        configure(4, 1, 4, 4'h0);
        run_random(5);

        configure(5, 7, 6, 4'h1);
        run_random(30);

        configure(8, 2, 3, 4'h0);
        run_random(25);

        configure(6, 5, 8, 4'h3);
        run_random(25);

        configure(4, 4, 4, 4'h0);
        run_random(15);

        drain(30);
        if (tracker.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/m3dor_pkg.sv
rtl/core/m3dor_cfg.sv
rtl/core/m3dor_front.sv
rtl/core/m3dor_jobq.sv
rtl/core/m3dor_back.sv
rtl/core/mesh3d_dimension_order_route_top.sv
tb/tb_top.sv
